FILE: design/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg: free-list allocator shared types
// Request/response beat structs, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int unsigned HdrBytes = 8;
  localparam int unsigned MinNode  = 16;
  localparam int unsigned ResetPool  = 8192;
  localparam int unsigned ResetAlign = 8;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StZeroReq   = 3'd1,
    StOom       = 3'd2,
    StNullFree  = 3'd3,
    StNothing   = 3'd4,
    StBadFree   = 3'd5,
    StTableFull = 3'd6
  } status_e;

  localparam logic [1:0] CfgPool  = 2'd0;
  localparam logic [1:0] CfgAlign = 2'd1;
  localparam logic [1:0] CfgFit   = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [23:0] request_size;
    logic [23:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] data_offset;
    logic [23:0] block_size;
    logic [23:0] bytes_used;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, reset scan
    logic scan;      // step segment scan one entry
    logic lscan;     // step live-slot scan one entry
    logic commit;    // apply table update
    logic shift;     // one shift step of segment table
    logic respond;   // drive result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic early_err;   // zero request / null free / nothing allocated
    logic scan_done;
    logic lscan_done;
    logic fail;        // oom / bad free / table full after scans
    logic shift_done;
  } sts_t;

endpackage

FILE: design/fla_ctrl.sv
// ----------------------------------------------------------------------------
// fla_ctrl: request sequencer
// Steps the datapath through check, scans, table update and response.
// ----------------------------------------------------------------------------
module fla_ctrl import fla_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SCheck = 6'b000010,
    SScan  = 6'b000100,
    SLive  = 6'b001000,
    SShift = 6'b010000,
    SResp  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (sts_i.early_err) state_d = SResp;
        else state_d = sts_i.is_free ? SLive : SScan;
      end
      SScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.is_free) state_d = sts_i.fail ? SResp : SShift;
          else state_d = sts_i.fail ? SResp : SLive;
        end
      end
      SLive: begin
        cmd_o.lscan = 1'b1;
        if (sts_i.lscan_done) begin
          if (sts_i.fail) state_d = SResp;
          else if (sts_i.is_free) state_d = SScan;
          else state_d = SShift;
        end
      end
      SShift: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          cmd_o.commit = 1'b1;
          state_d = SResp;
        end
      end
      SResp: begin
        cmd_o.respond = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != SIdle);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_resp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.respond |=> !busy_o)
    else $error("no return to idle after response");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request not started");

endmodule

FILE: design/fla_dp.sv
// ----------------------------------------------------------------------------
// fla_dp: allocator datapath
// Segment table, live-block table, scan pointers, size math and usage count.
// ----------------------------------------------------------------------------
module fla_dp import fla_pkg::*; #(
  parameter int unsigned NSeg  = 16,
  parameter int unsigned NLive = 16,
  parameter int unsigned OffW  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  req_t        req_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        valid_o,
  output rsp_t        rsp_o
);

  localparam int unsigned SW = (NSeg > 1) ? $clog2(NSeg) : 1;
  localparam int unsigned CW = $clog2(NSeg + 1);
  localparam int unsigned LW = (NLive > 1) ? $clog2(NLive) : 1;
  localparam int unsigned XW = ((OffW > 24) ? OffW : 24) + 2;

  logic [OffW-1:0] seg_start_q [NSeg];
  logic [OffW-1:0] seg_size_q  [NSeg];
  logic [CW-1:0]   seg_cnt_q;
  logic [OffW-1:0] live_start_q [NLive];
  logic [OffW-1:0] live_size_q  [NLive];
  logic [NLive-1:0] live_valid_q;
  logic [OffW-1:0] usage_q;

  logic [12:0]     align_q;
  logic            fit_q;

  logic        mode_q;
  logic [23:0] req_size_q, off_q;
  logic [XW-1:0] need_q;
  logic [CW-1:0] idx_q;       // segment scan pointer / free insert position
  logic [SW-1:0] pick_q;
  logic          found_q;
  logic [OffW-1:0] left_q;
  logic [LW:0]   lidx_q;
  logic [LW-1:0] slot_q;
  logic [2:0]    st_q;
  logic [OffW-1:0] bs_q, doff_q;
  logic [OffW-1:0] fstart_q, fsize_q;
  logic          mprev_q, mnext_q;
  logic          valid_q;

  // allocation size
  logic [XW-1:0] g0, g1, amask, need_d;
  always_comb begin
    logic [12:0] a;
    a = align_q;
    if (a < 13'd8 || (a & (a - 13'd1)) != 13'd0) a = 13'd8;
    g0 = XW'(req_i.request_size);
    if (req_i.request_size < 24'(MinNode)) g0 = g0 + XW'(MinNode);
    g1 = g0 + XW'(HdrBytes);
    amask = XW'(a) - XW'(1);
    need_d = (g1 + amask) & ~amask;
  end

  logic [OffW-1:0] cfg_pool;
  assign cfg_pool = OffW'(cfg_data_i);

  // current scan entry
  logic [SW-1:0]   si;
  logic [OffW-1:0] cur_start, cur_size;
  logic            in_range;
  assign si        = idx_q[SW-1:0];
  assign in_range  = idx_q < seg_cnt_q;
  assign cur_start = seg_start_q[si];
  assign cur_size  = seg_size_q[si];

  logic            fits;
  logic [OffW-1:0] cur_left;
  assign fits     = {{(XW-OffW){1'b0}}, cur_size} >= need_q;
  assign cur_left = cur_size - need_q[OffW-1:0];

  logic [LW-1:0] li;
  assign li = lidx_q[LW-1:0];
  logic [OffW-1:0] offw;
  assign offw = OffW'(off_q);

  // free path: insert position is idx_q after scan
  logic [XW-1:0] fend;
  assign fend = XW'(fstart_q) + XW'(fsize_q);

  logic scan_stop;
  always_comb begin
    scan_stop = !in_range;
    if (in_range) begin
      if (mode_q) scan_stop = cur_start > fstart_q;
      else scan_stop = fits && (!fit_q || cur_left == '0);
    end
  end

  // merge decisions at the insert position
  logic [SW-1:0] pm1;
  logic mprev_d, mnext_d;
  assign pm1 = si - SW'(1);
  assign mnext_d = in_range && (fend[OffW-1:0] == cur_start) && fend[XW-1:OffW] == '0;
  assign mprev_d = (idx_q != '0) &&
                   (XW'(seg_start_q[pm1]) + XW'(seg_size_q[pm1]) == XW'(fstart_q));

  logic need_shift_up, need_shift_dn;
  always_comb begin
    need_shift_dn = 1'b0;
    need_shift_up = 1'b0;
    if (mode_q) begin
      need_shift_dn = mprev_q && mnext_q;
      need_shift_up = !mprev_q && !mnext_q;
    end else begin
      need_shift_dn = (left_q == '0);
    end
  end

  // shift phase: sh_q walks from the hole toward the end (down) or end to hole (up)
  logic [CW-1:0] hole;
  assign hole = mode_q ? idx_q : CW'(pick_q);
  logic [CW-1:0] sh_q;

  always_comb begin
    sts_o = '0;
    sts_o.is_free   = mode_q;
    sts_o.early_err = mode_q ? (off_q == '0 || usage_q == '0) : (req_size_q == '0);
    sts_o.scan_done = scan_stop;
    sts_o.lscan_done = (lidx_q == (LW+1)'(NLive)) ||
                       (mode_q ? (live_valid_q[li] && live_start_q[li] + OffW'(HdrBytes) == offw)
                               : !live_valid_q[li]);
    sts_o.fail = 1'b0;
    if (cmd_i.scan) begin
      if (mode_q) sts_o.fail = !mnext_d && !mprev_d && seg_cnt_q >= CW'(NSeg);
      else sts_o.fail = !(found_q || (in_range && fits));
    end
    if (cmd_i.lscan) sts_o.fail = (lidx_q == (LW+1)'(NLive));
    if (need_shift_dn) sts_o.shift_done = (sh_q + CW'(1) >= seg_cnt_q);
    else if (need_shift_up) sts_o.shift_done = (sh_q <= hole);
    else sts_o.shift_done = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q      <= 13'(ResetAlign);
      fit_q        <= 1'b0;
      seg_cnt_q    <= (OffW'(ResetPool) != '0) ? CW'(1) : '0;
      live_valid_q <= '0;
      usage_q      <= '0;
      valid_q      <= 1'b0;
      seg_start_q[0] <= '0;
      seg_size_q[0]  <= OffW'(ResetPool);
    end else begin
      valid_q <= cmd_i.respond;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPool: begin
            seg_start_q[0] <= '0;
            seg_size_q[0]  <= cfg_pool;
            seg_cnt_q    <= (cfg_pool != '0) ? CW'(1) : '0;
            live_valid_q <= '0;
            usage_q      <= '0;
          end
          CfgAlign: align_q <= cfg_data_i[12:0];
          CfgFit:   fit_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.shift && !sts_o.shift_done) begin
        if (need_shift_dn) begin
          seg_start_q[sh_q[SW-1:0]] <= seg_start_q[sh_q[SW-1:0] + SW'(1)];
          seg_size_q[sh_q[SW-1:0]]  <= seg_size_q[sh_q[SW-1:0] + SW'(1)];
        end else begin
          seg_start_q[sh_q[SW-1:0]] <= seg_start_q[sh_q[SW-1:0] - SW'(1)];
          seg_size_q[sh_q[SW-1:0]]  <= seg_size_q[sh_q[SW-1:0] - SW'(1)];
        end
      end
      if (cmd_i.commit) begin
        if (mode_q) begin
          live_valid_q[slot_q] <= 1'b0;
          usage_q <= usage_q - fsize_q;
          if (mprev_q && mnext_q) begin
            // removal shift already moved entries; merged size came from saved copy
            seg_size_q[hole[SW-1:0] - SW'(1)] <=
              seg_size_q[hole[SW-1:0] - SW'(1)] + fsize_q + left_q;
            seg_cnt_q <= seg_cnt_q - CW'(1);
          end else if (mprev_q) begin
            seg_size_q[hole[SW-1:0] - SW'(1)] <= seg_size_q[hole[SW-1:0] - SW'(1)] + fsize_q;
          end else if (mnext_q) begin
            seg_start_q[hole[SW-1:0]] <= fstart_q;
            seg_size_q[hole[SW-1:0]]  <= seg_size_q[hole[SW-1:0]] + fsize_q;
          end else begin
            seg_start_q[hole[SW-1:0]] <= fstart_q;
            seg_size_q[hole[SW-1:0]]  <= fsize_q;
            seg_cnt_q <= seg_cnt_q + CW'(1);
          end
        end else begin
          live_valid_q[slot_q] <= 1'b1;
          usage_q <= usage_q + need_q[OffW-1:0];
          if (left_q != '0) begin
            seg_start_q[pick_q] <= fstart_q + need_q[OffW-1:0];
            seg_size_q[pick_q]  <= left_q;
          end else begin
            seg_cnt_q <= seg_cnt_q - CW'(1);
          end
        end
      end
    end
  end

  // live table payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !mode_q) begin
      live_start_q[slot_q] <= fstart_q;
      live_size_q[slot_q]  <= need_q[OffW-1:0];
    end
  end

  // request / scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      st_q   <= StOk;
    end else begin
      if (cmd_i.load) begin
        mode_q     <= req_i.mode;
        req_size_q <= req_i.request_size;
        off_q      <= req_i.free_offset;
        need_q     <= need_d;
        idx_q      <= '0;
        lidx_q     <= '0;
        found_q    <= 1'b0;
        bs_q       <= '0;
        doff_q     <= '0;
        st_q       <= req_i.mode ? ((req_i.free_offset == '0) ? StNullFree : StNothing)
                                 : StZeroReq;
      end
      if (cmd_i.scan) begin
        if (mode_q) begin
          if (scan_stop) begin
            mprev_q <= mprev_d;
            mnext_q <= mnext_d;
            left_q  <= in_range ? cur_size : '0;
            sh_q    <= mnext_d && mprev_d ? idx_q : seg_cnt_q;
            if (sts_o.fail) begin
              st_q   <= StTableFull;
            end
          end else idx_q <= idx_q + CW'(1);
        end else begin
          if (in_range && fits && (!found_q || cur_left < left_q)) begin
            found_q  <= 1'b1;
            pick_q   <= si;
            left_q   <= cur_left;
            fstart_q <= cur_start;
          end
          if (!scan_stop) idx_q <= idx_q + CW'(1);
          else if (sts_o.fail) begin
            st_q   <= StOom;
          end
        end
      end
      if (cmd_i.lscan) begin
        if (sts_o.lscan_done) begin
          slot_q <= li;
          if (sts_o.fail) begin
            st_q   <= mode_q ? StBadFree : StTableFull;
          end else if (mode_q) begin
            fstart_q <= live_start_q[li];
            fsize_q  <= live_size_q[li];
          end else begin
            sh_q <= CW'(pick_q);
          end
        end else lidx_q <= lidx_q + (LW+1)'(1);
      end
      if (cmd_i.shift) begin
        if (!sts_o.shift_done) begin
          sh_q <= need_shift_dn ? sh_q + CW'(1) : sh_q - CW'(1);
        end
        if (cmd_i.commit) begin
          st_q <= StOk;
          if (mode_q) bs_q <= fsize_q;
          else begin
            bs_q   <= need_q[OffW-1:0];
            doff_q <= fstart_q + OffW'(HdrBytes);
          end
        end
      end
    end
  end

  assign valid_o = valid_q;
  always_comb begin
    rsp_o = '0;
    rsp_o.status      = st_q;
    rsp_o.data_offset = 24'(doff_q);
    rsp_o.block_size  = 24'(bs_q);
    rsp_o.bytes_used  = 24'(usage_q);
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) seg_cnt_q <= CW'(NSeg))
    else $error("segment count overflow");
  a_ok_sz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == StOk) |-> rsp_o.block_size != '0)
    else $error("ok result with zero size");
  a_fail_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status != StOk) |-> rsp_o.data_offset == '0)
    else $error("failed result carries offset");

endmodule

FILE: design/free_list_allocator.sv
// ----------------------------------------------------------------------------
// free_list_allocator: first/best-fit pool allocator with coalescing free
// Usage:
//   Request: drive req_i and raise start while busy is low; the beat is
//   taken at that edge. mode 0 allocates request_size bytes, mode 1 frees
//   the block whose data offset is free_offset.
//   Result: one rsp_o beat per request shows for one cycle with valid_o high,
//   in the cycle in which busy drops; it cannot be stalled, so the receiver
//   must take it then.
//   Steps: accept, check, segment scan and live slot scan (live slot scan
//   first for a free), table shift and update, response. A zero request, a
//   null free or a free with nothing allocated skips the scans and the
//   update; a failed scan skips the shift and update. One request is in
//   flight at a time and the next can be taken in the result cycle.
//   Config: cfg_we_i/cfg_idx_i/cfg_data_i write pool_size (0), alignment (1)
//   and fit_policy (2) while idle. A pool_size write rebuilds one free
//   segment, drops all live blocks and zeroes usage.
//   Reset: pool 8192 bytes, alignment 8, first fit, one free segment.
// ----------------------------------------------------------------------------
module free_list_allocator import fla_pkg::*; #(
  parameter int unsigned MAX_FREE_SEGMENTS = 16,
  parameter int unsigned MAX_LIVE_BLOCKS   = 16,
  parameter int unsigned OFFSET_BITS       = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        valid_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  fla_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  fla_dp #(
    .NSeg  (MAX_FREE_SEGMENTS),
    .NLive (MAX_LIVE_BLOCKS),
    .OffW  (OFFSET_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .valid_o    (valid_o),
    .rsp_o      (rsp_o)
  );

endmodule

FILE: tb/free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// free_list_allocator_test: self-checking bench for the free-list allocator
// Feeds allocate/free beats from a queue through a start/busy driver, keeps
// its own copy of the segment table, live blocks and usage count to predict
// every response beat, and compares each beat field by field. Runs through
// several pool, alignment and fit settings with random sender idling.
// ----------------------------------------------------------------------------
module free_list_allocator_test;
  import fla_pkg::*;

  localparam int NumSeg   = 16;
  localparam int NumLive  = 16;
  localparam int CycLimit = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_r = 1'b0;
  logic        busy;
  req_t        req_r = '0;
  logic        valid_o;
  rsp_t        rsp_o;
  logic        cfg_we_r = 1'b0;
  logic [1:0]  cfg_idx_r = '0;
  logic [23:0] cfg_data_r = '0;

  free_list_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start_r),
    .busy       (busy),
    .req_i      (req_r),
    .valid_o    (valid_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_r),
    .cfg_idx_i  (cfg_idx_r),
    .cfg_data_i (cfg_data_r)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // allocator shadow state
  longint pool_bytes, align_reg;
  bit     best_fit;
  longint seg_start [NumSeg];
  longint seg_size  [NumSeg];
  int     seg_cnt;
  longint blk_start [NumLive];
  longint blk_size  [NumLive];
  bit     blk_live  [NumLive];
  longint used_bytes;

  req_t   item_q [$];
  rsp_t   rsp_expected [$];
  int     idle_pct = 17;
  bit     beat_taken = 1'b0;
  int     errors = 0;
  int     cycles = 0;

  function automatic void rebuild_pool();
    for (int i = 0; i < NumSeg; i++) begin
      seg_start[i] = 0;
      seg_size[i]  = 0;
    end
    for (int i = 0; i < NumLive; i++) begin
      blk_live[i] = 1'b0;
      blk_start[i] = 0;
      blk_size[i] = 0;
    end
    seg_size[0] = pool_bytes;
    seg_cnt = (pool_bytes != 0) ? 1 : 0;
    used_bytes = 0;
  endfunction

  function automatic void seg_drop(int i);
    for (int k = i; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_size[k]  = seg_size[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic void seg_add(int i, longint st, longint sz);
    for (int k = seg_cnt; k > i; k--) begin
      seg_start[k] = seg_start[k-1];
      seg_size[k]  = seg_size[k-1];
    end
    seg_start[i] = st;
    seg_size[i]  = sz;
    seg_cnt++;
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [23:0] val);
    if (idx == CfgPool) begin
      pool_bytes = val;
      rebuild_pool();
    end else if (idx == CfgAlign) begin
      align_reg = val[12:0];
    end else if (idx == CfgFit) begin
      best_fit = val[0];
    end
  endfunction

  function automatic rsp_t allocate_or_free(req_t rq);
    rsp_t   r;
    longint sz, a, left, best_left, st;
    int     pick, slot, pos;
    bit     found, mprev, mnext;
    r = '0;
    r.status = StOk;
    found = 1'b0; pick = 0; best_left = 0;
    if (!rq.mode) begin
      if (rq.request_size == 0) r.status = StZeroReq;
      else begin
        sz = rq.request_size;
        if (sz < MinNode) sz += MinNode;
        sz += HdrBytes;
        a = align_reg;
        if (a < 8 || (a & (a - 1)) != 0) a = 8;
        sz += (a - (sz & (a - 1))) & (a - 1);
        for (int i = 0; i < seg_cnt; i++) begin
          if (seg_size[i] >= sz) begin
            left = seg_size[i] - sz;
            if (!found || left < best_left) begin
              found = 1'b1; pick = i; best_left = left;
            end
            if (!best_fit || left == 0) break;
          end
        end
        slot = NumLive;
        for (int i = NumLive - 1; i >= 0; i--) if (!blk_live[i]) slot = i;
        if (!found) r.status = StOom;
        else if (slot == NumLive) r.status = StTableFull;
        else begin
          blk_live[slot] = 1'b1;
          blk_start[slot] = seg_start[pick];
          blk_size[slot] = sz;
          r.data_offset = 24'(seg_start[pick] + HdrBytes);
          r.block_size = 24'(sz);
          if (best_left != 0) begin
            seg_start[pick] += sz;
            seg_size[pick] = best_left;
          end else seg_drop(pick);
          used_bytes = (used_bytes + sz) & 64'hFFFFFF;
        end
      end
    end else begin
      slot = NumLive;
      for (int i = NumLive - 1; i >= 0; i--)
        if (blk_live[i] && blk_start[i] + HdrBytes == rq.free_offset) slot = i;
      if (rq.free_offset == 0) r.status = StNullFree;
      else if (used_bytes == 0) r.status = StNothing;
      else if (slot == NumLive) r.status = StBadFree;
      else begin
        st = blk_start[slot];
        sz = blk_size[slot];
        pos = seg_cnt;
        for (int i = seg_cnt - 1; i >= 0; i--) if (seg_start[i] > st) pos = i;
        mnext = pos < seg_cnt && st + sz == seg_start[pos];
        mprev = pos > 0 && seg_start[pos-1] + seg_size[pos-1] == st;
        if (!mnext && !mprev && seg_cnt >= NumSeg) r.status = StTableFull;
        else begin
          blk_live[slot] = 1'b0;
          used_bytes = (used_bytes - sz) & 64'hFFFFFF;
          r.block_size = 24'(sz);
          if (mprev && mnext) begin
            seg_size[pos-1] += sz + seg_size[pos];
            seg_drop(pos);
          end else if (mprev) seg_size[pos-1] += sz;
          else if (mnext) begin
            seg_start[pos] = st;
            seg_size[pos] += sz;
          end else seg_add(pos, st, sz);
        end
      end
    end
    r.bytes_used = 24'(used_bytes);
    return r;
  endfunction

  // sender: one beat at a time, random idling between beats
  always @(negedge clk_i) begin
    req_t nxt;
    logic go;
    nxt = req_r;
    go = start_r;
    if (rst_ni) begin
      if (start_r && beat_taken) go = 1'b0;
      if (!go && item_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = item_q.pop_front();
        go = 1'b1;
      end
      start_r <= go;
      req_r <= nxt;
    end
  end

  // monitor: config mirror, prediction on accept, response check
  always @(posedge clk_i) begin
    rsp_t e;
    beat_taken = 1'b0;
    if (rst_ni) begin
      cycles++;
      if (cfg_we_r) apply_cfg(cfg_idx_r, cfg_data_r);
      if (start_r && !busy) begin
        beat_taken = 1'b1;
        rsp_expected.insert(rsp_expected.size(), allocate_or_free(req_r));
      end
      if (valid_o) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t: unexpected response beat %h", $time, rsp_o);
          errors++;
        end else begin
          e = rsp_expected.pop_front();
          if (rsp_o.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, rsp_o.status);
            errors++;
          end
          if (rsp_o.data_offset !== e.data_offset) begin
            $display("%0t: data_offset exp %h got %h", $time, e.data_offset,
                     rsp_o.data_offset);
            errors++;
          end
          if (rsp_o.block_size !== e.block_size) begin
            $display("%0t: block_size exp %h got %h", $time, e.block_size,
                     rsp_o.block_size);
            errors++;
          end
          if (rsp_o.bytes_used !== e.bytes_used) begin
            $display("%0t: bytes_used exp %h got %h", $time, e.bytes_used,
                     rsp_o.bytes_used);
            errors++;
          end
        end
      end
      if (cycles > CycLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_alloc(logic [23:0] sz);
    req_t rq;
    rq.mode = 1'b0;
    rq.request_size = sz;
    rq.free_offset = 24'($urandom);
    item_q.insert(item_q.size(), rq);
  endtask

  task automatic push_free(logic [23:0] off);
    req_t rq;
    rq.mode = 1'b1;
    rq.request_size = 24'($urandom);
    rq.free_offset = off;
    item_q.insert(item_q.size(), rq);
  endtask

  task automatic drain();
    while (item_q.size() != 0 || start_r || rsp_expected.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_r <= 1'b1;
    cfg_idx_r <= idx;
    cfg_data_r <= val;
    @(negedge clk_i);
    cfg_we_r <= 1'b0;
  endtask

  function automatic logic [23:0] live_offset();
    int picks [$];
    for (int i = 0; i < NumLive; i++) if (blk_live[i]) picks.insert(picks.size(), i);
    if (picks.size() == 0) return 24'($urandom_range(1, 4096));
    return 24'(blk_start[picks[$urandom_range(0, picks.size() - 1)]] + HdrBytes);
  endfunction

  // mostly well-formed alloc/free traffic, some noise
  task automatic random_batch(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 3) push_alloc(24'd0);
      else if (k < 8) push_alloc(24'($urandom));
      else if (k < 20) push_alloc(24'($urandom_range(1, 40)));
      else if (k < 55) push_alloc(24'($urandom_range(1, 700)));
      else if (k < 88) push_free(live_offset());
      else if (k < 91) push_free(24'd0);
      else if (k < 95) push_free(live_offset() + 24'd8);
      else push_free(24'($urandom));
    end
  endtask

  initial begin
    logic [23:0] pools  [6] = '{24'd8192, 24'd64, 24'd600, 24'hFFFFFF, 24'd0, 24'd2048};
    logic [23:0] aligns [6] = '{24'd8, 24'd4096, 24'd16, 24'd8191, 24'd0, 24'd64};
    pool_bytes = ResetPool;
    align_reg = ResetAlign;
    best_fit = 1'b0;
    rebuild_pool();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: error paths, field extremes, live table fill
    push_free(24'd8);
    push_free(24'd0);
    push_alloc(24'd0);
    push_alloc(24'hFFFFFF);
    push_alloc(24'd1);
    push_alloc(24'd15);
    push_alloc(24'd16);
    push_free(24'hFFFFFF);
    for (int i = 0; i < 14; i++) push_alloc(24'd100);
    drain();
    push_free(live_offset());
    push_free(live_offset());
    push_free(live_offset());

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 87 : 0;
      for (int s = 0; s < 6; s++) begin
        drain();
        repeat (4) @(posedge clk_i);
        cfg_write(CfgAlign, aligns[(s + ph) % 6]);
        cfg_write(CfgFit, 24'((s + ph) & 1));
        cfg_write(CfgPool, pools[s]);
        for (int b = 0; b < 7; b++) begin
          random_batch(6);
          drain();
        end
      end
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/fla_pkg.sv
design/fla_ctrl.sv
design/fla_dp.sv
design/free_list_allocator.sv
tb/free_list_allocator_test.sv
